// ===== hdl/leb_pkg.sv =====
package leb_pkg;

	// Command codes
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_BACK   = 3'd1;
	localparam logic [2:0] MODE_LEFT   = 3'd2;
	localparam logic [2:0] MODE_RIGHT  = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;
	localparam logic [2:0] MODE_READ   = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_in;
		logic [7:0] read_index;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] char_out;
		logic [8:0] line_length;
		logic [8:0] cursor_at;
	} rsp_beat_t;

endpackage

// ===== hdl/line_edit_buffer.sv =====
// line_edit_buffer: one editable line of bytes with a cursor, kept in a text RAM.
// Left, right, clear and refused or no-effect commands load the result register as the
// beat is taken; a read inside the line reads the RAM, then S_RD loads the result; insert
// and backspace run S_SHIFT, then S_FIN loads it. Throughput: one command at a time; the
// shift moves one byte per cycle via the single read and single write port of the RAM.
// Reset: arst_n clears length, cursor and control; the text RAM is not cleared.
module line_edit_buffer #(
	parameter int LINE_CAP = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  leb_pkg::cmd_beat_t  cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output leb_pkg::rsp_beat_t  rsp
);
	import leb_pkg::*;

	// Address width of the text RAM, and width of length/cursor (they reach LINE_CAP).
	localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
	localparam int LW = $clog2(LINE_CAP + 1);
	// Compare width that holds both an 8-bit read index and a length.
	localparam int CW = (LW > 8) ? LW : 8;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_FIN   = 4'b0100,
		S_RD    = 4'b1000
	} state_t;

	state_t         state_q;

	// Line state
	logic [LW-1:0]  length_q;
	logic [LW-1:0]  cursor_q;

	// Shift bookkeeping: next address to read, bytes still to read, op and byte to insert
	logic [AW-1:0]  ptr_q;
	logic [LW-1:0]  cnt_q;
	logic           is_ins_q;
	logic [7:0]     ch_q;

	// Write-back stage of the read-modify-write shift
	logic           wb_s1;
	logic [AW-1:0]  wb_addr_s1;
	logic [7:0]     rd_data_s1;

	// Result register
	logic           rsp_valid_q;
	rsp_beat_t      rsp_q;

	// Text RAM and its ports
	logic [7:0]     text_mem [LINE_CAP];
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;

	logic           cmd_acc;
	logic           rd_ok;
	logic           full;
	logic           load;
	rsp_beat_t      load_beat;

	// Take a command only when idle and the result register is free (or draining now).
	// A shift never loads the result register early, so it is free again when the shift ends.
	assign cmd_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign full  = (length_q == LW'(LINE_CAP));
	assign rd_ok = (CW'(cmd.read_index) < CW'(length_q)) &&
	               (CW'(cmd.read_index) < CW'(LINE_CAP));

	// Text RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = wb_addr_s1;
		wr_data = rd_data_s1;
		unique case (state_q)
			S_IDLE: begin
				// Indexed read: issue now, data lands next cycle
				rd_en   = cmd_acc && (cmd.mode == MODE_READ) && rd_ok;
				rd_addr = AW'(cmd.read_index);
			end
			S_SHIFT: begin
				rd_en   = (cnt_q != '0);
				rd_addr = ptr_q;
				wr_en   = wb_s1;
			end
			S_FIN: begin
				// Drop the new byte into the gap at the cursor
				wr_en   = is_ins_q;
				wr_addr = cursor_q[AW-1:0];
				wr_data = ch_q;
			end
			S_RD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= text_mem[rd_addr];
		end
		if (wr_en) begin
			text_mem[wr_addr] <= wr_data;
		end
	end

	// Result that lands in the result register this cycle, if any
	always_comb begin
		load                  = 1'b0;
		load_beat.status      = ST_NONE;
		load_beat.char_out    = 8'd0;
		load_beat.line_length = 9'(length_q);
		load_beat.cursor_at   = 9'(cursor_q);
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					load = 1'b1;
					unique case (cmd.mode)
						MODE_INSERT: begin
							// Accepted inserts go through the shift; only refusal answers here
							load             = full;
							load_beat.status = ST_FULL;
						end
						MODE_BACK: begin
							load = (cursor_q == '0);
						end
						MODE_LEFT: begin
							if (cursor_q != '0) begin
								load_beat.status    = ST_DONE;
								load_beat.cursor_at = 9'(cursor_q - LW'(1));
							end
						end
						MODE_RIGHT: begin
							if (cursor_q != length_q) begin
								load_beat.status    = ST_DONE;
								load_beat.cursor_at = 9'(cursor_q + LW'(1));
							end
						end
						MODE_CLEAR: begin
							load_beat.status      = ST_DONE;
							load_beat.line_length = 9'd0;
							load_beat.cursor_at   = 9'd0;
						end
						MODE_READ: begin
							// Valid reads answer from S_RD with the RAM data
							load = !rd_ok;
						end
						default: begin
						end
					endcase
				end
			end
			S_FIN: begin
				load             = 1'b1;
				load_beat.status = ST_DONE;
				if (is_ins_q) begin
					load_beat.line_length = 9'(length_q + LW'(1));
					load_beat.cursor_at   = 9'(cursor_q + LW'(1));
				end else begin
					load_beat.line_length = 9'(length_q - LW'(1));
					load_beat.cursor_at   = 9'(cursor_q - LW'(1));
				end
			end
			S_RD: begin
				load               = 1'b1;
				load_beat.status   = ST_DONE;
				load_beat.char_out = rd_data_s1;
			end
			S_SHIFT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and line registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			length_q <= '0;
			cursor_q <= '0;
			wb_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					wb_s1 <= 1'b0;
					if (cmd_acc) begin
						unique case (cmd.mode)
							MODE_INSERT: begin
								if (!full) begin
									state_q <= S_SHIFT;
								end
							end
							MODE_BACK: begin
								if (cursor_q != '0) begin
									state_q <= S_SHIFT;
								end
							end
							MODE_LEFT: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - LW'(1);
								end
							end
							MODE_RIGHT: begin
								if (cursor_q != length_q) begin
									cursor_q <= cursor_q + LW'(1);
								end
							end
							MODE_CLEAR: begin
								length_q <= '0;
								cursor_q <= '0;
							end
							MODE_READ: begin
								if (rd_ok) begin
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					// Advance one byte per cycle; the last write-back drains before finishing
					wb_s1 <= (cnt_q != '0);
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					if (is_ins_q) begin
						length_q <= length_q + LW'(1);
						cursor_q <= cursor_q + LW'(1);
					end else begin
						length_q <= length_q - LW'(1);
						cursor_q <= cursor_q - LW'(1);
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Shift datapath: insert walks the tail downward moving each byte up by one,
	// backspace walks it upward moving each byte down by one. A read and the
	// write-back in the same cycle never touch the same entry.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (cmd_acc) begin
				is_ins_q <= (cmd.mode == MODE_INSERT);
				ch_q     <= cmd.char_in;
				cnt_q    <= length_q - cursor_q;
				if (cmd.mode == MODE_INSERT) begin
					ptr_q <= AW'(length_q - LW'(1));
				end else begin
					ptr_q <= cursor_q[AW-1:0];
				end
			end
		end else if (state_q == S_SHIFT) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - LW'(1);
				if (is_ins_q) begin
					ptr_q      <= ptr_q - AW'(1);
					wb_addr_s1 <= ptr_q + AW'(1);
				end else begin
					ptr_q      <= ptr_q + AW'(1);
					wb_addr_s1 <= ptr_q - AW'(1);
				end
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= load_beat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import leb_pkg::*;

	localparam int LINE_CAP    = 256;
	localparam int CYCLE_LIMIT = 1_000_000;

	// Opcodes the block leaves unused; they must come back as no-effect beats.
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	// Shadow copy of the line: predicts one reply per accepted command beat
	// and checks the replies against those predictions in order.
	class line_shadow;
		logic [7:0] text [LINE_CAP];
		int         len;
		int         cur;
		rsp_beat_t  replies_due[$];
		int         errors;

		function void apply_edit(cmd_beat_t c);
			rsp_beat_t r;
			int        k;
			r        = '0;
			r.status = ST_NONE;
			case (c.mode)
				MODE_INSERT: begin
					if (len >= LINE_CAP) begin
						r.status = ST_FULL;
					end else begin
						for (k = len; k > cur; k--) text[k] = text[k - 1];
						text[cur] = c.char_in;
						len++;
						cur++;
						r.status = ST_DONE;
					end
				end
				MODE_BACK: begin
					if (cur > 0) begin
						for (k = cur - 1; k < len - 1; k++) text[k] = text[k + 1];
						len--;
						cur--;
						r.status = ST_DONE;
					end
				end
				MODE_LEFT: begin
					if (cur > 0) begin
						cur--;
						r.status = ST_DONE;
					end
				end
				MODE_RIGHT: begin
					if (cur < len) begin
						cur++;
						r.status = ST_DONE;
					end
				end
				MODE_CLEAR: begin
					len      = 0;
					cur      = 0;
					r.status = ST_DONE;
				end
				MODE_READ: begin
					if (int'(c.read_index) < len) begin
						r.char_out = text[c.read_index];
						r.status   = ST_DONE;
					end
				end
				default: ;
			endcase
			r.line_length = len[8:0];
			r.cursor_at   = cur[8:0];
			replies_due.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(rsp_beat_t got);
			rsp_beat_t want;
			if (replies_due.size() == 0) begin
				$error("reply beat with no command pending: %h", got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			compare_field("status", int'(want.status), int'(got.status));
			compare_field("char_out", int'(want.char_out), int'(got.char_out));
			compare_field("line_length", int'(want.line_length), int'(got.line_length));
			compare_field("cursor_at", int'(want.cursor_at), int'(got.cursor_at));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_beat_t cmd;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	int          tx_idle_pct;
	int          rx_idle_pct;
	int unsigned cycle_count = 0;
	line_shadow  shadow = new();

	line_edit_buffer #(
		.LINE_CAP(LINE_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a correct run finishes far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Reply side: check each accepted beat, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) shadow.check_reply(rsp);
		rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Drive one command beat; idle the sender first at random, hold the beat
	// until it is taken, then note it in the shadow.
	task automatic send_edit(input cmd_beat_t beat);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= beat;
		do @(posedge clk); while (cmd_stall);
		shadow.apply_edit(beat);
	endtask

	task automatic send_fields(input logic [2:0] mode, input logic [7:0] ch,
			input logic [7:0] idx);
		cmd_beat_t beat;
		beat.mode       = mode;
		beat.char_in    = ch;
		beat.read_index = idx;
		send_edit(beat);
	endtask

	task automatic directed_edits();
		send_fields(MODE_READ, 8'h00, 8'h00);     // read on an empty line
		send_fields(MODE_BACK, 8'hFF, 8'hFF);     // backspace at the start
		send_fields(MODE_LEFT, 8'h00, 8'h00);     // left at the start
		send_fields(MODE_RIGHT, 8'h00, 8'h00);    // right at the end
		send_fields(MODE_INSERT, 8'h00, 8'hFF);
		send_fields(MODE_INSERT, 8'hFF, 8'h00);
		send_fields(MODE_LEFT, 8'h00, 8'h00);
		send_fields(MODE_INSERT, 8'hA5, 8'h00);   // insert in the middle
		send_fields(MODE_READ, 8'h00, 8'h00);
		send_fields(MODE_READ, 8'h00, 8'h01);
		send_fields(MODE_READ, 8'h00, 8'h02);
		send_fields(MODE_READ, 8'hFF, 8'hFF);     // read past the end
		send_fields(MODE_RIGHT, 8'h00, 8'h00);
		send_fields(MODE_RIGHT, 8'h00, 8'h00);    // right at the end again
		send_fields(MODE_LEFT, 8'h00, 8'h00);
		send_fields(MODE_BACK, 8'h00, 8'h00);     // backspace in the middle
		send_fields(MODE_READ, 8'h00, 8'h01);
		send_fields(MODE_SPARE6, 8'hFF, 8'hFF);
		send_fields(MODE_SPARE7, 8'h00, 8'h00);
		send_fields(MODE_CLEAR, 8'h00, 8'h00);
		send_fields(MODE_READ, 8'h00, 8'h00);     // old bytes must not read back
		send_fields(MODE_INSERT, 8'h5A, 8'h00);
		send_fields(MODE_BACK, 8'h00, 8'h00);
		send_fields(MODE_CLEAR, 8'hFF, 8'hFF);    // clear on an empty line
	endtask

	// Mixed editing with random content; reads mostly land inside the line.
	task automatic mixed_edits(input int count);
		int         n;
		int         pick;
		logic [2:0] mode;
		logic [7:0] idx;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			idx  = 8'($urandom_range(0, 255));
			if (pick < 38) mode = MODE_INSERT;
			else if (pick < 50) mode = MODE_BACK;
			else if (pick < 61) mode = MODE_LEFT;
			else if (pick < 72) mode = MODE_RIGHT;
			else if (pick < 75) mode = MODE_CLEAR;
			else if (pick < 96) begin
				mode = MODE_READ;
				if (shadow.len > 0 && $urandom_range(0, 3) != 0)
					idx = 8'($urandom_range(0, shadow.len - 1));
			end else begin
				mode = pick[0] ? MODE_SPARE6 : MODE_SPARE7;
			end
			send_fields(mode, 8'($urandom_range(0, 255)), idx);
		end
	endtask

	// Grow the line to capacity with the cursor wandering, so shifts vary in
	// length, then work the edges of a full line.
	task automatic fill_line();
		int pick;
		while (shadow.len < LINE_CAP) begin
			pick = $urandom_range(0, 99);
			if (pick < 18 && shadow.cur > 0) send_fields(MODE_LEFT, 8'h00, 8'h00);
			else if (pick < 22) send_fields(MODE_RIGHT, 8'h00, 8'h00);
			else send_fields(MODE_INSERT, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
		end
		repeat (3) send_fields(MODE_INSERT, 8'($urandom_range(0, 255)), 8'h00);
		while (shadow.cur < shadow.len) send_fields(MODE_RIGHT, 8'h00, 8'h00);
		send_fields(MODE_RIGHT, 8'hFF, 8'hFF);
		send_fields(MODE_READ, 8'h00, 8'hFF);
		send_fields(MODE_READ, 8'hFF, 8'h00);
		send_fields(MODE_READ, 8'h00, 8'($urandom_range(0, 255)));
		send_fields(MODE_INSERT, 8'h3C, 8'h00);
		send_fields(MODE_BACK, 8'h00, 8'h00);
		send_fields(MODE_INSERT, 8'hC3, 8'h00);
		send_fields(MODE_LEFT, 8'h00, 8'h00);
		send_fields(MODE_INSERT, 8'h77, 8'h00);
		send_fields(MODE_READ, 8'h00, 8'hFE);
	endtask

	initial begin
		int phase;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		tx_idle_pct = 35;
		rx_idle_pct = 64;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		directed_edits();

		// Phases: receiver-heavy idling, sender-heavy idling, then none.
		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 64 : 0;
			rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 35 : 0;
			mixed_edits(160);
			if (phase == 0) fill_line();
		end
		cmd_valid <= 1'b0;

		// Drain, then allow one worst-case shift for anything stray.
		while (shadow.replies_due.size() != 0) @(posedge clk);
		repeat (LINE_CAP + 4) @(posedge clk);

		if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/leb_pkg.sv
hdl/line_edit_buffer.sv
tb/sv/tb_top.sv
